// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the matrix multiply engine modules.
// Each macro expects signals named clk and rst_n in the using scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MME_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mme_pkg.sv
// ---------------------------------------------------------------------------
// mme_pkg
// Types and constants shared by the matrix multiply engine modules.
// ---------------------------------------------------------------------------
package mme_pkg;

    // Field widths fixed by the item format.
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 35;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Request codes.
    localparam logic [1:0] REQ_WRITE_A = 2'd0;
    localparam logic [1:0] REQ_WRITE_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

    // Clamped matrix dimensions.
    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } dims_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
        logic             acc_clr;
        logic             out_load;
        logic             out_last;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/mme_req_if.sv
// ---------------------------------------------------------------------------
// mme_req_if
// Request channel: element writes and compute commands.
// ---------------------------------------------------------------------------
interface mme_req_if;

    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element_value;

    modport source (
        output valid,
        output req_type,
        output row_index,
        output col_index,
        output element_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  row_index,
        input  col_index,
        input  element_value,
        output ready
    );

endinterface

// File: hdl/mme_res_if.sv
// ---------------------------------------------------------------------------
// mme_res_if
// Result channel: one transaction per element of the product matrix.
// ---------------------------------------------------------------------------
interface mme_res_if;

    logic               valid;
    logic               ready;
    logic signed [34:0] product_value;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last_element;

    modport source (
        output valid,
        output product_value,
        output out_row,
        output out_col,
        output last_element,
        input  ready
    );

    modport sink (
        input  valid,
        input  product_value,
        input  out_row,
        input  out_col,
        input  last_element,
        output ready
    );

endinterface

// File: hdl/matrix_multiply_engine_unit.sv
// ---------------------------------------------------------------------------
// matrix_multiply_engine_unit
// Dense matrix product R = A x B, Q8.8 elements and Q19.16 results.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on req_chan. A write of A or B may be followed by another
// request in the next cycle; writes outside the configured dimensions are
// dropped. A compute request stalls req_chan (ready low) until every element
// of R has been handed to the output register.
// Results leave on res_chan in row-major order, last_element set on the final
// one. Each element runs the inner loop on one shared MAC fed by the single
// read port of each element memory, then drains the MAC's multiply and
// accumulate stages and loads the sum into the output register.
// The output register holds a result while the receiver stalls; the MAC
// waits for it with the next sum ready and resumes when it is taken.
// Reset sets all dimensions to 8 and empties the MAC and output register; the
// element memories are not cleared and must be written before use.
// Dimension registers lie at byte addresses 0, 4 and 8 of the APB port; the
// user must write them only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module matrix_multiply_engine_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mme_req_if.sink                     req_chan,
    mme_res_if.source                   res_chan,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mme_pkg::APB_AW-1:0]  paddr,
    input  logic [mme_pkg::APB_DW-1:0]  pwdata,
    output logic [mme_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import mme_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] inner_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             cfg_write;
    dims_t            dims;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    // Zero is used as one and values above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    // APB register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_RESET;
            inner_reg <= DIM_RESET;
            cols_reg  <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ROWS_OF_A:  rows_reg  <= pwdata[DIM_W-1:0];
                REG_INNER_SIZE: inner_reg <= pwdata[DIM_W-1:0];
                REG_COLS_OF_B:  cols_reg  <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS_OF_A:  prdata = {{(APB_DW-DIM_W){1'b0}}, rows_reg};
            REG_INNER_SIZE: prdata = {{(APB_DW-DIM_W){1'b0}}, inner_reg};
            REG_COLS_OF_B:  prdata = {{(APB_DW-DIM_W){1'b0}}, cols_reg};
            default:        prdata = '0;
        endcase
    end

    // Dimensions in effect.
    assign dims.nr = clamp_dim(rows_reg);
    assign dims.nk = clamp_dim(inner_reg);
    assign dims.nc = clamp_dim(cols_reg);

    // Controller and datapath.
    mme_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_chan),
        .dims   (dims),
        .status (status),
        .cmd    (cmd)
    );

    mme_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_data (req_chan.element_value),
        .status  (status),
        .res     (res_chan)
    );

endmodule

// File: hdl/mme_ctrl.sv
// ---------------------------------------------------------------------------
// mme_ctrl
// Controller: accepts requests, walks the row, column and inner indexes and
// sequences the datapath's memories, MAC and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mme_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    mme_req_if.sink             req,
    input  mme_pkg::dims_t      dims,
    input  mme_pkg::dp_status_t status,
    output mme_pkg::ctrl_cmd_t  cmd
);
    import mme_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] y_reg, y_next;
    logic [IDX_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic req_fire;
    logic in_range_a;
    logic in_range_b;
    logic k_last;
    logic x_last;
    logic y_last;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // Range checks against the configured dimensions.
    assign in_range_a = (DIM_W'(req.row_index) < dims.nr) &&
                        (DIM_W'(req.col_index) < dims.nk);
    assign in_range_b = (DIM_W'(req.row_index) < dims.nk) &&
                        (DIM_W'(req.col_index) < dims.nc);

    assign k_last = (DIM_W'(k_reg) + DIM_W'(1)) == dims.nk;
    assign x_last = (DIM_W'(x_reg) + DIM_W'(1)) == dims.nc;
    assign y_last = (DIM_W'(y_reg) + DIM_W'(1)) == dims.nr;

    // Next-state and command logic.
    always_comb
    begin
        state_next   = state_reg;
        y_next       = y_reg;
        x_next       = x_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.row      = y_reg;
        cmd.col      = x_reg;
        cmd.k        = k_reg;
        cmd.out_last = x_last && y_last;

        case (state_reg)
            S_IDLE:
            begin
                cmd.row = req.row_index;
                cmd.col = req.col_index;
                if (req_fire)
                begin
                    case (req.req_type)
                        REQ_WRITE_A: cmd.wr_a = in_range_a;
                        REQ_WRITE_B: cmd.wr_b = in_range_b;
                        REQ_COMPUTE:
                        begin
                            y_next      = '0;
                            x_next      = '0;
                            k_next      = '0;
                            cmd.acc_clr = 1'b1;
                            state_next  = S_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end

            S_ISSUE:
            begin
                cmd.rd_en = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end

            S_DRAIN:
            begin
                // Hand the sum over once the MAC is empty and the output has room.
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    if (x_last && y_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                        if (x_last)
                        begin
                            x_next = '0;
                            y_next = y_reg + IDX_W'(1);
                        end
                        else
                        begin
                            x_next = x_reg + IDX_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            y_reg     <= '0;
            x_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            y_reg     <= y_next;
            x_reg     <= x_next;
            k_reg     <= k_next;
        end
    end

    // Checks on the sequencing.
    `MME_IMPLIES(a_load_when_ready, cmd.out_load, status.out_free && !status.pipe_busy, "output loaded while MAC busy or output full")
    `MME_NEXT(a_compute_starts, req_fire && req.req_type == REQ_COMPUTE, state_reg == S_ISSUE && k_reg == '0 && y_reg == '0 && x_reg == '0, "compute did not start at the first element")
    `MME_NEXT(a_last_ends, cmd.out_load && cmd.out_last, state_reg == S_IDLE, "controller did not return to idle after the last element")

endmodule

// File: hdl/mme_datapath.sv
// ---------------------------------------------------------------------------
// mme_datapath
// Datapath: element memories for A and B, one shared multiply-accumulate
// unit and the output register of the result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mme_datapath #(
    parameter int MAX_DIM = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mme_pkg::ctrl_cmd_t         cmd,
    input  logic signed [15:0]         wr_data,
    output mme_pkg::dp_status_t        status,
    mme_res_if.source                  res
);
    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);

    logic signed [VAL_W-1:0]  mem_a_reg [DEPTH];
    logic signed [VAL_W-1:0]  mem_b_reg [DEPTH];
    logic signed [VAL_W-1:0]  a_rd_reg;
    logic signed [VAL_W-1:0]  b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     v1_reg;
    logic                     v2_reg;

    logic                     out_valid_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic                     out_last_reg;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;

    // Row-major addressing: row * MAX_DIM + column.
    assign wr_addr   = ADDR_W'(cmd.row) * DIM_A + ADDR_W'(cmd.col);
    assign rd_addr_a = ADDR_W'(cmd.row) * DIM_A + ADDR_W'(cmd.k);
    assign rd_addr_b = ADDR_W'(cmd.k) * DIM_A + ADDR_W'(cmd.col);

    // Element memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
        begin
            mem_a_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            a_rd_reg <= mem_a_reg[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
        begin
            mem_b_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            b_rd_reg <= mem_b_reg[rd_addr_b];
        end
    end

    // Multiply stage and accumulate stage.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= a_rd_reg * b_rd_reg;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Pipeline occupancy flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.out_free  = !out_valid_reg || res.ready;

    // Output register: holds one result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= acc_reg;
            out_row_reg   <= cmd.row;
            out_col_reg   <= cmd.col;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.product_value = out_value_reg;
    assign res.out_row       = out_row_reg;
    assign res.out_col       = out_col_reg;
    assign res.last_element  = out_last_reg;

    // Checks on the MAC pipeline and output register.
    `MME_NEXT(a_load_shows, cmd.out_load, out_valid_reg, "loaded result not presented")
    `MME_NEXT(a_acc_cleared, cmd.acc_clr, acc_reg == '0, "accumulator not cleared")
    `MME_IMPLIES(a_pipe_order, v2_reg, $past(v1_reg), "accumulate stage without a multiply")

endmodule

// File: bench/mme_product_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mme_product_checker
// Passive checker for the matrix multiply engine. It follows the register
// port and the request channel to keep its own copy of the dimensions and of
// both element stores. On every accepted compute request it queues the full
// product matrix in row-major order, and it compares each accepted result
// field by field with the oldest queued element.
// ---------------------------------------------------------------------------
module mme_product_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // Request channel
    input  logic                                     req_valid,
    input  logic                                     req_ready,
    input  logic [1:0]                               req_type,
    input  logic [mme_pkg::IDX_W-1:0]                row_index,
    input  logic [mme_pkg::IDX_W-1:0]                col_index,
    input  logic signed [mme_pkg::VAL_W-1:0]         element_value,
    // Result channel
    input  logic                                     res_valid,
    input  logic                                     res_ready,
    input  logic signed [mme_pkg::ACC_W-1:0]         product_value,
    input  logic [mme_pkg::IDX_W-1:0]                out_row,
    input  logic [mme_pkg::IDX_W-1:0]                out_col,
    input  logic                                     last_element,
    // Register port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic                                     pready,
    input  logic [mme_pkg::APB_AW-1:0]               paddr,
    input  logic [mme_pkg::APB_DW-1:0]               pwdata,
    // Status for the test top
    output int                                       failures,
    output int                                       outstanding,
    output int                                       checked
);
    import mme_pkg::*;

    localparam int DIM_MAX     = 8;
    localparam int REPORT_LIMIT = 10;

    // One element of the product matrix as it should appear on the output.
    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
    } product_elem_t;

    logic [DIM_W-1:0]        rows_reg  = 4'd8;
    logic [DIM_W-1:0]        inner_reg = 4'd8;
    logic [DIM_W-1:0]        cols_reg  = 4'd8;
    logic signed [VAL_W-1:0] a_copy [DIM_MAX*DIM_MAX];
    logic signed [VAL_W-1:0] b_copy [DIM_MAX*DIM_MAX];
    product_elem_t           pending_products [$];
    int                      mismatch_count = 0;
    int                      pending_count  = 0;
    int                      result_count   = 0;

    assign failures    = mismatch_count;
    assign outstanding = pending_count;
    assign checked     = result_count;

    // A dimension register of zero acts as one; anything above the maximum
    // acts as the maximum.
    function automatic int effective_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (int'(raw) > DIM_MAX)
            return DIM_MAX;
        return int'(raw);
    endfunction

    // Queue every element of R = A x B for the current dimensions.
    task automatic queue_product_matrix();
        int            nr;
        int            nk;
        int            nc;
        longint        sum;
        product_elem_t elem;
        nr = effective_dim(rows_reg);
        nk = effective_dim(inner_reg);
        nc = effective_dim(cols_reg);
        for (int y = 0; y < nr; y++)
        begin
            for (int x = 0; x < nc; x++)
            begin
                sum = 0;
                for (int k = 0; k < nk; k++)
                    sum += longint'(a_copy[y*DIM_MAX+k]) * longint'(b_copy[k*DIM_MAX+x]);
                elem.value = sum[ACC_W-1:0];
                elem.row   = y[IDX_W-1:0];
                elem.col   = x[IDX_W-1:0];
                elem.last  = (y == nr - 1) && (x == nc - 1);
                pending_products.push_back(elem);
            end
        end
    endtask

    // Apply one accepted request to the predicted state.
    task automatic apply_request();
        int nr;
        int nk;
        int nc;
        nr = effective_dim(rows_reg);
        nk = effective_dim(inner_reg);
        nc = effective_dim(cols_reg);
        case (req_type)
            REQ_WRITE_A:
            begin
                if (int'(row_index) < nr && int'(col_index) < nk)
                    a_copy[row_index*DIM_MAX+col_index] = element_value;
            end
            REQ_WRITE_B:
            begin
                if (int'(row_index) < nk && int'(col_index) < nc)
                    b_copy[row_index*DIM_MAX+col_index] = element_value;
            end
            REQ_COMPUTE:
            begin
                queue_product_matrix();
            end
            default:
            begin
                // The spare request code has no effect.
            end
        endcase
    endtask

    // Compare one accepted result with the oldest queued element.
    task automatic check_result();
        product_elem_t want;
        result_count++;
        if (pending_products.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: result with nothing expected: value %0d row %0d col %0d last %0b",
                         $realtime, product_value, out_row, out_col, last_element);
        end
        else
        begin
            want = pending_products.pop_front();
            if (product_value !== want.value || out_row !== want.row ||
                out_col !== want.col || last_element !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("    expected value %0d row %0d col %0d last %0b",
                             want.value, want.row, want.col, want.last);
                    $display("    actual   value %0d row %0d col %0d last %0b",
                             product_value, out_row, out_col, last_element);
                end
            end
        end
    endtask

    // Follow all three ports on the rising edge; the dimensions return to
    // their reset values while rst_n is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  = 4'd8;
            inner_reg = 4'd8;
            cols_reg  = 4'd8;
            pending_products.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ROWS_OF_A:  rows_reg  = pwdata[DIM_W-1:0];
                    REG_INNER_SIZE: inner_reg = pwdata[DIM_W-1:0];
                    REG_COLS_OF_B:  cols_reg  = pwdata[DIM_W-1:0];
                    default:        ;
                endcase
            end
            if (res_valid && res_ready)
                check_result();
            if (req_valid && req_ready)
                apply_request();
        end
        pending_count = pending_products.size();
    end

endmodule

// File: bench/tb_matrix_multiply_engine_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_matrix_multiply_engine_unit
// Stimulus and verdict for the matrix multiply engine. A short directed part
// covers the value extremes, out-of-range dimensions, dropped writes and the
// spare request code; random phases then load operands at random dimension
// settings and request products, with random idle bursts on both channels
// and one long receiver hold-off. Checking is done by mme_product_checker.
// ---------------------------------------------------------------------------
module tb_matrix_multiply_engine_unit;

    import mme_pkg::*;

    localparam int         CLK_HALF        = 5;
    localparam int         DIM_MAX         = 8;
    localparam int         ITEM_TARGET     = 420;
    localparam int         CALM_TAIL       = 80;
    localparam int         QUIET_CYCLES    = 16;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         PRESSURE_PHASE  = 3;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam logic [1:0] REQ_UNUSED      = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    mme_req_if req_chan ();
    mme_res_if res_chan ();

    int chk_failures;
    int chk_outstanding;
    int chk_checked;

    // Stimulus bookkeeping
    int cur_rows;
    int cur_inner;
    int cur_cols;
    bit a_written [DIM_MAX*DIM_MAX];
    bit b_written [DIM_MAX*DIM_MAX];
    bit idle_on;
    bit rx_holding;
    int hold_cycles;
    int useful_items;
    int computes_sent;
    int settings_used;
    int stall_cycles;

    matrix_multiply_engine_unit #(
        .MAX_DIM (DIM_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_chan (req_chan),
        .res_chan (res_chan),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mme_product_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_chan.valid),
        .req_ready     (req_chan.ready),
        .req_type      (req_chan.req_type),
        .row_index     (req_chan.row_index),
        .col_index     (req_chan.col_index),
        .element_value (req_chan.element_value),
        .res_valid     (res_chan.valid),
        .res_ready     (res_chan.ready),
        .product_value (res_chan.product_value),
        .out_row       (res_chan.out_row),
        .out_col       (res_chan.out_col),
        .last_element  (res_chan.last_element),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .failures      (chk_failures),
        .outstanding   (chk_outstanding),
        .checked       (chk_checked)
    );

    // Clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Watchdog: ends the run when no transaction of any kind is seen for
    // too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_chan.valid && req_chan.ready) ||
            (res_chan.valid && res_chan.ready) || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results still due",
                     $realtime, WATCHDOG_LIMIT, chk_outstanding);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        res_chan.ready <= 1'b0;
        rx_holding = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                res_chan.ready <= 1'b0;
                rx_holding = 1'b1;
                repeat (hold_cycles) @(posedge clk);
                rx_holding = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_chan.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                res_chan.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic int effective_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (int'(raw) > DIM_MAX)
            return DIM_MAX;
        return int'(raw);
    endfunction

    // Element values lean toward the Q8.8 extremes now and then.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // One register write: setup then access. The bus is left selected so
    // that writes can follow back to back.
    task automatic write_register(input logic [1:0] reg_idx, input logic [DIM_W-1:0] raw);
        logic [APB_DW-1:0] noise;
        noise = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {noise[APB_DW-1:DIM_W], raw};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
    endtask

    task automatic set_dimensions(input logic [DIM_W-1:0] rows_raw,
                                  input logic [DIM_W-1:0] inner_raw,
                                  input logic [DIM_W-1:0] cols_raw);
        write_register(REG_ROWS_OF_A, rows_raw);
        write_register(REG_INNER_SIZE, inner_raw);
        write_register(REG_COLS_OF_B, cols_raw);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_rows  = effective_dim(rows_raw);
        cur_inner = effective_dim(inner_raw);
        cur_cols  = effective_dim(cols_raw);
        settings_used++;
    endtask

    // Offer one request, with an optional idle burst first, and return at
    // the edge where it is accepted.
    task automatic send_request(input logic [1:0] kind, input logic [2:0] row,
                                input logic [2:0] col, input logic [VAL_W-1:0] value);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_chan.valid         <= 1'b1;
        req_chan.req_type      <= kind;
        req_chan.row_index     <= row;
        req_chan.col_index     <= col;
        req_chan.element_value <= value;
        do
            @(negedge clk);
        while (!req_chan.ready);
        @(posedge clk);
        // Keep track of which elements hold a written value.
        if (kind == REQ_WRITE_A && row < cur_rows && col < cur_inner)
        begin
            a_written[row*DIM_MAX+col] = 1'b1;
            useful_items++;
        end
        else if (kind == REQ_WRITE_B && row < cur_inner && col < cur_cols)
        begin
            b_written[row*DIM_MAX+col] = 1'b1;
            useful_items++;
        end
        else if (kind == REQ_COMPUTE)
        begin
            computes_sent++;
            useful_items++;
        end
    endtask

    // Write any operand element the next product would read unwritten.
    task automatic load_missing_operands();
        for (int r = 0; r < cur_rows; r++)
            for (int k = 0; k < cur_inner; k++)
                if (!a_written[r*DIM_MAX+k])
                    send_request(REQ_WRITE_A, 3'(r), 3'(k), pick_value());
        for (int k = 0; k < cur_inner; k++)
            for (int c = 0; c < cur_cols; c++)
                if (!b_written[k*DIM_MAX+c])
                    send_request(REQ_WRITE_B, 3'(k), 3'(c), pick_value());
    endtask

    task automatic request_product();
        load_missing_operands();
        send_request(REQ_COMPUTE, 3'($urandom()), 3'($urandom()), VAL_W'($urandom()));
    endtask

    // Random write that lands inside the current dimensions.
    task automatic write_inside();
        if ($urandom_range(0, 1) == 0)
            send_request(REQ_WRITE_A, 3'($urandom_range(0, cur_rows - 1)),
                         3'($urandom_range(0, cur_inner - 1)), pick_value());
        else
            send_request(REQ_WRITE_B, 3'($urandom_range(0, cur_inner - 1)),
                         3'($urandom_range(0, cur_cols - 1)), pick_value());
    endtask

    // Let every expected result arrive, then a few quiet cycles, so that the
    // block is idle before the dimensions change.
    task automatic wait_idle();
        req_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (chk_outstanding != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Main stimulus
    initial
    begin
        int          phase;
        int          pick;
        logic [3:0]  rows_raw;
        logic [3:0]  inner_raw;
        logic [3:0]  cols_raw;

        rst_n                  = 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        req_chan.valid        <= 1'b0;
        req_chan.req_type     <= REQ_WRITE_A;
        req_chan.row_index    <= '0;
        req_chan.col_index    <= '0;
        req_chan.element_value <= '0;
        idle_on       = 1'b1;
        hold_cycles   = 0;
        useful_items  = 0;
        computes_sent = 0;
        settings_used = 0;
        cur_rows      = DIM_MAX;
        cur_inner     = DIM_MAX;
        cur_cols      = DIM_MAX;
        foreach (a_written[i])
        begin
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Directed: zero-sized dimensions act as one; extreme products.
        set_dimensions(4'd0, 4'd1, 4'd0);
        send_request(REQ_WRITE_A, 3'd0, 3'd0, 16'h7FFF);
        send_request(REQ_WRITE_B, 3'd0, 3'd0, 16'h7FFF);
        send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_request(REQ_WRITE_A, 3'd0, 3'd0, 16'h8000);
        send_request(REQ_WRITE_B, 3'd0, 3'd0, 16'h8000);
        send_request(REQ_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
        send_request(REQ_WRITE_B, 3'd0, 3'd0, 16'h7FFF);
        send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
        // Writes outside the 1x1 shape and the spare code change nothing.
        send_request(REQ_WRITE_A, 3'd0, 3'd1, 16'h1234);
        send_request(REQ_WRITE_B, 3'd1, 3'd0, 16'h5678);
        send_request(REQ_WRITE_A, 3'd7, 3'd7, 16'hFFFF);
        send_request(REQ_UNUSED, 3'd7, 3'd7, 16'hFFFF);
        send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
        wait_idle();

        // Directed: register values above the maximum act as the maximum.
        set_dimensions(4'd15, 4'd9, 4'd8);
        send_request(REQ_WRITE_A, 3'd7, 3'd7, 16'hFFFF);
        send_request(REQ_WRITE_B, 3'd7, 3'd7, 16'h8000);
        send_request(REQ_WRITE_A, 3'd7, 3'd0, 16'h0001);
        send_request(REQ_WRITE_B, 3'd0, 3'd7, 16'h7FFF);
        send_request(REQ_UNUSED, 3'd0, 3'd0, 16'h0000);

        // Random phases: operand loads and products at changing shapes.
        // Stores keep their contents across every change of dimensions.
        phase = 0;
        while (useful_items < ITEM_TARGET)
        begin
            phase++;
            wait_idle();
            pick = $urandom_range(0, 9);
            if (phase == PRESSURE_PHASE)
            begin
                rows_raw  = 4'd4;
                inner_raw = 4'd2;
                cols_raw  = 4'd4;
            end
            else if (pick == 0)
            begin
                rows_raw  = 4'($urandom_range(0, 15));
                inner_raw = 4'($urandom_range(0, 15));
                cols_raw  = 4'($urandom_range(0, 15));
            end
            else if (pick == 1)
            begin
                rows_raw  = ($urandom_range(0, 1) == 0) ? 4'd8 : 4'd15;
                inner_raw = 4'd8;
                cols_raw  = ($urandom_range(0, 1) == 0) ? 4'd8 : 4'd12;
            end
            else
            begin
                rows_raw  = 4'($urandom_range(1, 4));
                inner_raw = 4'($urandom_range(1, 4));
                cols_raw  = 4'($urandom_range(1, 4));
            end
            set_dimensions(rows_raw, inner_raw, cols_raw);
            if (useful_items > ITEM_TARGET - CALM_TAIL)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);

            repeat ($urandom_range(6, 24))
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    write_inside();
                else if (pick < 16)
                    send_request(($urandom_range(0, 1) == 0) ? REQ_WRITE_A : REQ_WRITE_B,
                                 3'($urandom()), 3'($urandom()), pick_value());
                else if (pick == 16)
                    send_request(REQ_UNUSED, 3'($urandom()), 3'($urandom()),
                                 VAL_W'($urandom()));
                else
                    request_product();
            end

            if (phase == PRESSURE_PHASE)
            begin
                // Receiver holds off while more requests queue up behind the
                // product, so the output register and the input both stall.
                // The request bus stays quiet until the hold-off has begun.
                load_missing_operands();
                req_chan.valid <= 1'b0;
                hold_cycles = HOLD_OFF_CYCLES;
                while (!rx_holding)
                    @(posedge clk);
                hold_cycles = 0;
                send_request(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
                repeat (8) write_inside();
            end
            else
            begin
                request_product();
            end
        end

        wait_idle();
        $display("Covered %0d useful requests, %0d products and %0d dimension settings;",
                 useful_items, computes_sent, settings_used);
        $display("%0d result elements checked, including a %0d-cycle receiver hold-off.",
                 chk_checked, HOLD_OFF_CYCLES);
        if (chk_failures == 0 && chk_outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d failures, %0d results never arrived", chk_failures, chk_outstanding);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
